### hdl/assert_macros.svh
// Assertion helpers shared by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define FPN_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked in every cycle, reset included.
`define FPN_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### hdl/fpn_pkg.sv
`default_nettype none
package fpn_pkg;

    localparam int TABLE_SIZE_DEF  = 256;
    localparam int MAX_OCTAVES_DEF = 8;
    localparam int COORD_BITS_DEF  = 12;

    localparam int CFG_DW = 16;
    localparam int CFG_AW = 2;

    typedef enum logic [CFG_AW-1:0] {
        CFG_BASE_FREQ = 2'd0,
        CFG_BASE_AMP  = 2'd1,
        CFG_OCTAVES   = 2'd2
    } t_cfg_reg;

    localparam logic [15:0] BASE_FREQ_RST = 16'd328;
    localparam logic [14:0] BASE_AMP_RST  = 15'd22938;
    localparam logic [3:0]  OCTAVES_RST   = 4'd8;

    typedef enum logic {
        OP_TABLE_WRITE = 1'b0,
        OP_PIXEL       = 1'b1
    } t_op;

    // Control that travels with every transaction down the chain.
    typedef struct packed {
        logic       valid;
        logic       pix;
        logic [7:0] widx;
        logic [7:0] wval;
    } t_ctl;

endpackage
`default_nettype wire

### hdl/fractal_perlin_noise_2d.sv
`default_nettype none
// Fractal 2D Perlin noise generator. Each pixel transaction (tuser = 1) returns one
// byte of noise summed over octave_count octaves; a table transaction (tuser = 0)
// loads one permutation entry and returns nothing. The permutation table must be
// fully loaded before pixels are sent. One transaction is taken every cycle unless
// a finished result is held on the output, which is the only stall. A pixel passes
// the entry register, one 8-stage cell per octave (each holding its own copies of
// the table), then the scale and output registers. Write the configuration registers
// only while no pixel is in flight. TABLE_SIZE must be a power of two.
module fractal_perlin_noise_2d #(
    parameter int TABLE_SIZE  = fpn_pkg::TABLE_SIZE_DEF,
    parameter int MAX_OCTAVES = fpn_pkg::MAX_OCTAVES_DEF,
    parameter int COORD_BITS  = fpn_pkg::COORD_BITS_DEF,
    localparam int S_DW = ((16 + 2 * COORD_BITS) + 7) / 8 * 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [fpn_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  wire logic [fpn_pkg::CFG_DW-1:0]  i_cfg_wdata,
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    // table_index, table_value, pixel_x, pixel_y
    input  wire logic [S_DW-1:0]             i_s_tdata,
    // op
    input  wire logic                        i_s_tuser,
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    // noise_value
    output logic [7:0]                       o_m_tdata
);

    localparam int PW = COORD_BITS + 16;
    localparam int SW = 35 + $clog2(MAX_OCTAVES);
    localparam int NW = $clog2(MAX_OCTAVES + 1);
    localparam int FW = SW + 8;
    localparam logic signed [FW-1:0] RND31 = FW'(64'd1 << 30);

    logic [15:0] r_base_freq;
    logic [14:0] r_base_amp;
    logic [3:0]  r_octaves;
    logic [NW-1:0] w_noct;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_freq <= fpn_pkg::BASE_FREQ_RST;
            r_base_amp  <= fpn_pkg::BASE_AMP_RST;
            r_octaves   <= fpn_pkg::OCTAVES_RST;
        end else if (i_cfg_we) begin
            case (fpn_pkg::t_cfg_reg'(i_cfg_addr))
                fpn_pkg::CFG_BASE_FREQ: r_base_freq <= i_cfg_wdata[15:0];
                fpn_pkg::CFG_BASE_AMP:  r_base_amp  <= i_cfg_wdata[14:0];
                fpn_pkg::CFG_OCTAVES:   r_octaves   <= i_cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // Clamp octave count to 1..MAX_OCTAVES.
    always_comb begin
        if (r_octaves == 4'd0) begin
            w_noct = NW'(1);
        end else if (32'(r_octaves) > MAX_OCTAVES) begin
            w_noct = NW'(MAX_OCTAVES);
        end else begin
            w_noct = NW'(r_octaves);
        end
    end

    logic w_en;
    logic r_out_valid;
    logic [7:0] r_out_data;

    // Advance everything unless a result is held.
    assign w_en       = !r_out_valid || i_m_tready;
    assign o_s_tready = w_en;

    // Entry stage: scale coordinates by the base frequency.
    fpn_pkg::t_ctl r_pre_ctl;
    logic [PW-1:0] r_pre_px, r_pre_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_ctl.valid <= 1'b0;
        end else if (w_en) begin
            r_pre_ctl.valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pre_ctl.pix  <= (i_s_tuser == fpn_pkg::OP_PIXEL);
            r_pre_ctl.widx <= i_s_tdata[7:0];
            r_pre_ctl.wval <= i_s_tdata[15:8];
            r_pre_px <= PW'(i_s_tdata[16 +: COORD_BITS] * r_base_freq);
            r_pre_py <= PW'(i_s_tdata[16 + COORD_BITS +: COORD_BITS] * r_base_freq);
        end
    end

    fpn_pkg::t_ctl        w_ctl [MAX_OCTAVES+1];
    logic [PW-1:0]        w_px  [MAX_OCTAVES+1];
    logic [PW-1:0]        w_py  [MAX_OCTAVES+1];
    logic signed [SW-1:0] w_sum [MAX_OCTAVES+1];

    assign w_ctl[0] = r_pre_ctl;
    assign w_px[0]  = r_pre_px;
    assign w_py[0]  = r_pre_py;
    assign w_sum[0] = '0;

    for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_cell
        fpn_cell #(
            .TABLE_SIZE (TABLE_SIZE),
            .MAX_OCTAVES(MAX_OCTAVES),
            .COORD_BITS (COORD_BITS),
            .OCT        (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (w_en),
            .i_octaves (w_noct),
            .i_base_amp(r_base_amp),
            .i_ctl     (w_ctl[g]),
            .i_px      (w_px[g]),
            .i_py      (w_py[g]),
            .i_sum     (w_sum[g]),
            .o_ctl     (w_ctl[g+1]),
            .o_px      (w_px[g+1]),
            .o_py      (w_py[g+1]),
            .o_sum     (w_sum[g+1])
        );
    end

    // Scale by 255, then round and saturate.
    logic                 r_f1_valid;
    logic signed [FW-1:0] r_f1;
    logic signed [FW-1:0] w_r;
    logic [7:0]           w_byte;

    assign w_r = (r_f1 + RND31) >>> 31;

    always_comb begin
        if (w_r < 0) begin
            w_byte = 8'd0;
        end else if (w_r > FW'(255)) begin
            w_byte = 8'd255;
        end else begin
            w_byte = w_r[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_f1_valid  <= w_ctl[MAX_OCTAVES].valid && w_ctl[MAX_OCTAVES].pix;
            r_out_valid <= r_f1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f1       <= (FW'(w_sum[MAX_OCTAVES]) <<< 8) - FW'(w_sum[MAX_OCTAVES]);
            r_out_data <= w_byte;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule
`default_nettype wire

### hdl/fpn_ram.sv
`default_nettype none
module fpn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr0,
    input  wire logic [AW-1:0]    i_raddr1,
    output logic      [WIDTH-1:0] o_rdata0,
    output logic      [WIDTH-1:0] o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata0 <= r_mem[i_raddr0];
            o_rdata1 <= r_mem[i_raddr1];
        end
    end

endmodule
`default_nettype wire

### hdl/fpn_cell.sv
`default_nettype none
module fpn_cell #(
    parameter int TABLE_SIZE  = fpn_pkg::TABLE_SIZE_DEF,
    parameter int MAX_OCTAVES = fpn_pkg::MAX_OCTAVES_DEF,
    parameter int COORD_BITS  = fpn_pkg::COORD_BITS_DEF,
    parameter int OCT         = 0,
    localparam int AW  = $clog2(TABLE_SIZE),
    localparam int PW  = COORD_BITS + 16,
    localparam int SW  = 35 + $clog2(MAX_OCTAVES),
    localparam int NW  = $clog2(MAX_OCTAVES + 1)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic [NW-1:0]      i_octaves,
    input  wire logic [14:0]        i_base_amp,
    input  wire fpn_pkg::t_ctl      i_ctl,
    input  wire logic [PW-1:0]      i_px,
    input  wire logic [PW-1:0]      i_py,
    input  wire logic signed [SW-1:0] i_sum,
    output fpn_pkg::t_ctl           o_ctl,
    output logic [PW-1:0]           o_px,
    output logic [PW-1:0]           o_py,
    output logic signed [SW-1:0]    o_sum
);

    localparam int SHW = PW + MAX_OCTAVES + AW;
    localparam int NST = 8;

    // Pass-through delay line, one slot per stage.
    fpn_pkg::t_ctl           r_ctl [1:NST];
    logic [PW-1:0]           r_px  [1:NST];
    logic [PW-1:0]           r_py  [1:NST];
    logic signed [SW-1:0]    r_sum [1:NST-1];
    logic signed [SW-1:0]    r_sum_out;

    // Entry: lattice cell and fraction for this octave.
    logic [SHW-1:0] w_xs, w_ys;
    logic [15:0]    w_fx, w_fy;
    logic [AW-1:0]  w_bx, w_by;
    logic [7:0]     w_h0, w_h1;
    logic [7:0]     w_h00, w_h01, w_h10, w_h11;

    assign w_xs = SHW'(i_px) << OCT;
    assign w_ys = SHW'(i_py) << OCT;
    assign w_fx = w_xs[15:0];
    assign w_fy = w_ys[15:0];
    assign w_bx = w_xs[16 +: AW];
    assign w_by = w_ys[16 +: AW];

    fpn_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (i_en && i_ctl.valid && !i_ctl.pix),
        .i_waddr (AW'(i_ctl.widx)),
        .i_wdata (i_ctl.wval),
        .i_re    (i_en),
        .i_raddr0(w_bx),
        .i_raddr1(w_bx + AW'(1)),
        .o_rdata0(w_h0),
        .o_rdata1(w_h1)
    );

    // Stage 1
    logic [15:0]   r1_fx, r1_fy;
    logic [AW-1:0] r1_by;
    logic [32:0]   w_t2x_p, w_t2y_p;
    logic          w_we1;

    assign w_t2x_p = 33'(r1_fx * r1_fx) + 33'd32768;
    assign w_t2y_p = 33'(r1_fy * r1_fy) + 33'd32768;
    assign w_we1   = i_en && r_ctl[1].valid && !r_ctl[1].pix;

    fpn_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_we1),
        .i_waddr (AW'(r_ctl[1].widx)),
        .i_wdata (r_ctl[1].wval),
        .i_re    (i_en),
        .i_raddr0(AW'(w_h0) + r1_by),
        .i_raddr1(AW'(w_h0) + r1_by + AW'(1)),
        .o_rdata0(w_h00),
        .o_rdata1(w_h01)
    );

    fpn_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram_c (
        .i_clk   (i_clk),
        .i_we    (w_we1),
        .i_waddr (AW'(r_ctl[1].widx)),
        .i_wdata (r_ctl[1].wval),
        .i_re    (i_en),
        .i_raddr0(AW'(w_h1) + r1_by),
        .i_raddr1(AW'(w_h1) + r1_by + AW'(1)),
        .o_rdata0(w_h10),
        .o_rdata1(w_h11)
    );

    // Stage 2: cube, fade polynomial, gradient dots
    logic [15:0]        r2_fx, r2_fy;
    logic [16:0]        r2_t2x, r2_t2y;
    logic [33:0]        w_t3x_p, w_t3y_p;
    logic signed [22:0] w_qx, w_qy;
    logic signed [17:0] w_dx0, w_dx1, w_dy0, w_dy1;
    logic signed [18:0] w_d00, w_d01, w_d10, w_d11;

    function automatic logic signed [18:0] grad_dot(input logic [7:0] h,
                                                     input logic signed [17:0] dx,
                                                     input logic signed [17:0] dy);
        logic signed [18:0] gx;
        logic signed [18:0] gy;
        gx = h[1] ? -19'(dx) : 19'(dx);
        gy = h[0] ? -19'(dy) : 19'(dy);
        return gx + gy;
    endfunction

    assign w_t3x_p = 34'(r2_t2x * r2_fx) + 34'd32768;
    assign w_t3y_p = 34'(r2_t2y * r2_fy) + 34'd32768;
    assign w_qx = 23'sd6 * $signed({6'd0, r2_t2x}) - 23'sd15 * $signed({7'd0, r2_fx})
                + 23'sd655360;
    assign w_qy = 23'sd6 * $signed({6'd0, r2_t2y}) - 23'sd15 * $signed({7'd0, r2_fy})
                + 23'sd655360;
    assign w_dx0 = $signed({2'b00, r2_fx});
    assign w_dy0 = $signed({2'b00, r2_fy});
    assign w_dx1 = w_dx0 - 18'sd65536;
    assign w_dy1 = w_dy0 - 18'sd65536;
    assign w_d00 = grad_dot(w_h00, w_dx0, w_dy0);
    assign w_d01 = grad_dot(w_h01, w_dx0, w_dy1);
    assign w_d10 = grad_dot(w_h10, w_dx1, w_dy0);
    assign w_d11 = grad_dot(w_h11, w_dx1, w_dy1);

    // Stage 3: fade product, clamp to one
    logic [16:0]        r3_t3x, r3_t3y;
    logic [20:0]        r3_qx, r3_qy;
    logic signed [18:0] r3_d00, r3_d01, r3_d10, r3_d11;
    logic [38:0]        w_fxp, w_fyp;
    logic [16:0]        w_sx, w_sy;

    assign w_fxp = (39'(r3_t3x * r3_qx) + 39'd32768) >> 16;
    assign w_fyp = (39'(r3_t3y * r3_qy) + 39'd32768) >> 16;
    assign w_sx  = (w_fxp > 39'd65536) ? 17'd65536 : w_fxp[16:0];
    assign w_sy  = (w_fyp > 39'd65536) ? 17'd65536 : w_fyp[16:0];

    // Stage 4: blend along y
    logic [16:0]        r4_sx, r4_sy;
    logic signed [18:0] r4_d00, r4_d01, r4_d10, r4_d11;
    logic signed [19:0] w_dl, w_dr;
    logic signed [37:0] w_pl, w_pr;
    logic signed [19:0] w_left, w_right;

    assign w_dl = 20'(r4_d01) - 20'(r4_d00);
    assign w_dr = 20'(r4_d11) - 20'(r4_d10);
    assign w_pl = 38'(w_dl) * 38'($signed({1'b0, r4_sy}));
    assign w_pr = 38'(w_dr) * 38'($signed({1'b0, r4_sy}));
    assign w_left  = 20'(r4_d00) + 20'((w_pl + 38'sd32768) >>> 16);
    assign w_right = 20'(r4_d10) + 20'((w_pr + 38'sd32768) >>> 16);

    // Stage 5: blend along x
    logic [16:0]        r5_sx;
    logic signed [19:0] r5_left, r5_right;
    logic signed [20:0] w_dv;
    logic signed [38:0] w_pv;
    logic signed [19:0] w_v;

    assign w_dv = 21'(r5_right) - 21'(r5_left);
    assign w_pv = 39'(w_dv) * 39'($signed({1'b0, r5_sx}));
    assign w_v  = r5_left + 20'((w_pv + 39'sd32768) >>> 16);

    // Stage 6: map to 0..1 and scale by amplitude
    logic signed [19:0] r6_v;
    logic signed [18:0] w_smp;
    logic [14:0]        w_amp;
    logic signed [34:0] w_prod;

    assign w_smp  = 19'((21'(r6_v) + 21'sd65537) >>> 1);
    assign w_amp  = i_base_amp >> OCT;
    assign w_prod = 35'(w_smp) * 35'($signed({1'b0, w_amp}));

    // Stage 7: accumulate when this octave is in use
    logic signed [34:0] r7_prod;
    logic               w_active;

    assign w_active = (i_octaves > NW'(OCT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= NST; k++) begin
                r_ctl[k].valid <= 1'b0;
            end
        end else if (i_en) begin
            r_ctl[1].valid <= i_ctl.valid;
            for (int k = 2; k <= NST; k++) begin
                r_ctl[k].valid <= r_ctl[k-1].valid;
            end
        end
        if (i_en) begin
            r_ctl[1].pix  <= i_ctl.pix;
            r_ctl[1].widx <= i_ctl.widx;
            r_ctl[1].wval <= i_ctl.wval;
            r_px[1]  <= i_px;
            r_py[1]  <= i_py;
            r_sum[1] <= i_sum;
            for (int k = 2; k <= NST; k++) begin
                r_ctl[k].pix  <= r_ctl[k-1].pix;
                r_ctl[k].widx <= r_ctl[k-1].widx;
                r_ctl[k].wval <= r_ctl[k-1].wval;
                r_px[k] <= r_px[k-1];
                r_py[k] <= r_py[k-1];
            end
            for (int k = 2; k < NST; k++) begin
                r_sum[k] <= r_sum[k-1];
            end

            r1_fx <= w_fx;
            r1_fy <= w_fy;
            r1_by <= w_by;

            r2_fx  <= r1_fx;
            r2_fy  <= r1_fy;
            r2_t2x <= w_t2x_p[32:16];
            r2_t2y <= w_t2y_p[32:16];

            r3_t3x <= w_t3x_p[32:16];
            r3_t3y <= w_t3y_p[32:16];
            r3_qx  <= w_qx[20:0];
            r3_qy  <= w_qy[20:0];
            r3_d00 <= w_d00;
            r3_d01 <= w_d01;
            r3_d10 <= w_d10;
            r3_d11 <= w_d11;

            r4_sx  <= w_sx;
            r4_sy  <= w_sy;
            r4_d00 <= r3_d00;
            r4_d01 <= r3_d01;
            r4_d10 <= r3_d10;
            r4_d11 <= r3_d11;

            r5_sx    <= r4_sx;
            r5_left  <= w_left;
            r5_right <= w_right;

            r6_v <= w_v;

            r7_prod <= w_prod;

            r_sum_out <= r_sum[NST-1] + (w_active ? SW'(r7_prod) : SW'(0));
        end
    end

    assign o_ctl = r_ctl[NST];
    assign o_px  = r_px[NST];
    assign o_py  = r_py[NST];
    assign o_sum = r_sum_out;

endmodule
`default_nettype wire

### hdl/fpn_checker.sv
`default_nettype none
`include "assert_macros.svh"
module fpn_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_s_tready,
    input wire logic       o_m_tvalid,
    input wire logic       i_m_tready,
    input wire logic [7:0] o_m_tdata
);

    `FPN_ASSERT(a_hold_out, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata), "result dropped or changed while stalled")
    `FPN_ASSERT_ALWAYS(a_rst_clear, !i_rst_n |=> !o_m_tvalid, "result valid right after reset")
    `FPN_ASSERT(a_ready_free, !o_m_tvalid |-> o_s_tready, "input stalled with output free")
    `FPN_ASSERT(a_ready_stall, o_m_tvalid && !i_m_tready |-> !o_s_tready, "input taken while output held")

endmodule

bind fractal_perlin_noise_2d fpn_checker u_fpn_checker (.*);
`default_nettype wire
